@@ hdl/pfg_pkg.sv @@
// Types, constants and register codes shared by the periodic frame generator.
`default_nettype none
package pfg_pkg;

   // Frame identifiers and fixed payload bytes.
   localparam logic [10:0] ID_SPEED_FRAME  = 11'd201;
   localparam logic [10:0] ID_ENGINE_FRAME = 11'd1217;
   localparam logic [10:0] ID_TRANS_FRAME  = 11'd505;
   localparam logic [10:0] ID_CODE_FRAME   = 11'd1984;
   localparam logic [7:0]  COOLANT_BYTE    = 8'd90;
   localparam logic [7:0]  OIL_BYTE        = 8'd40;
   localparam logic [7:0]  GEAR_VALUE      = 8'd3;
   localparam logic [15:0] OVERREV_CODE    = 16'h0217;

   // Byte counts of the four frame kinds.
   localparam logic [3:0] LEN_SPEED  = 4'd4;
   localparam logic [3:0] LEN_ENGINE = 4'd2;
   localparam logic [3:0] LEN_TRANS  = 4'd1;
   localparam logic [3:0] LEN_CODE   = 4'd2;

   // Register indexes on the configuration port.
   localparam logic [2:0] REG_PERIOD_SPEED  = 3'd0;
   localparam logic [2:0] REG_PERIOD_ENGINE = 3'd1;
   localparam logic [2:0] REG_PERIOD_TRANS  = 3'd2;
   localparam logic [2:0] REG_RPM_FLOOR     = 3'd3;
   localparam logic [2:0] REG_RPM_CEILING   = 3'd4;
   localparam logic [2:0] REG_RPM_INCREMENT = 3'd5;
   localparam logic [2:0] REG_SPEED_TOP     = 3'd6;
   localparam logic [2:0] REG_PROFILE_MODE  = 3'd7;

   // Register reset values.
   localparam logic [15:0] RST_PERIOD_SPEED  = 16'd100;
   localparam logic [15:0] RST_PERIOD_ENGINE = 16'd500;
   localparam logic [15:0] RST_PERIOD_TRANS  = 16'd200;
   localparam logic [15:0] RST_RPM_FLOOR     = 16'd700;
   localparam logic [15:0] RST_RPM_CEILING   = 16'd6000;
   localparam logic [15:0] RST_RPM_INCREMENT = 16'd50;
   localparam logic [15:0] RST_SPEED_TOP     = 16'd2500;

   // Profile mode codes.
   localparam logic [1:0] MODE_RAMP  = 2'd0;
   localparam logic [1:0] MODE_IDLE  = 2'd1;
   localparam logic [1:0] MODE_FAULT = 2'd2;

   // Input word kind code.
   localparam logic KIND_INJECT = 1'b1;

   // Configuration register set.
   typedef struct packed {
      logic [15:0] period_speed_ms;
      logic [15:0] period_engine_ms;
      logic [15:0] period_trans_ms;
      logic [15:0] rpm_floor;
      logic [15:0] rpm_ceiling;
      logic [15:0] rpm_increment;
      logic [15:0] speed_top_x10;
      logic [1:0]  profile_mode;
   } cfg_type;

   // Classified command passed from the front end to the back end.
   typedef struct packed {
      logic        inject;
      logic [15:0] code;
      logic        room;
      logic        speed_due;
      logic        engine_due;
      logic        trans_due;
   } cmd_type;

   // One outgoing frame.
   typedef struct packed {
      logic [10:0] frame_id;
      logic [3:0]  byte_count;
      logic [63:0] payload;
      logic        last;
   } frame_type;

   // Back-end sequencer states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_RAMP,
      ST_MULT,
      ST_DIV,
      ST_PLAN,
      ST_EMIT
   } back_state_type;

endpackage
`default_nettype wire

@@ hdl/pfg_req_if.sv @@
// Input channel interface: tick and inject words.
`default_nettype none
interface pfg_req_if;
   logic        valid;
   logic        ready;
   logic        kind;
   logic [31:0] now_ms;
   logic [15:0] trouble_code;
   logic        queue_has_room;

   modport source (output valid, kind, now_ms, trouble_code, queue_has_room, input ready);
   modport sink   (input valid, kind, now_ms, trouble_code, queue_has_room, output ready);
endinterface
`default_nettype wire

@@ hdl/pfg_rsp_if.sv @@
// Result channel interface: generated frames.
`default_nettype none
interface pfg_rsp_if;
   logic        valid;
   logic        ready;
   logic [10:0] frame_id;
   logic [3:0]  byte_count;
   logic [63:0] payload;
   logic        last;

   modport source (output valid, frame_id, byte_count, payload, last, input ready);
   modport sink   (input valid, frame_id, byte_count, payload, last, output ready);
endinterface
`default_nettype wire

@@ hdl/pfg_front.sv @@
// Front end: accepts input words, checks the period timers and classifies each word.
`default_nettype none
module pfg_front (
   input  wire logic            clock,
   input  wire logic            reset,
   pfg_req_if.sink              req_port,
   input  wire pfg_pkg::cfg_type cfg,
   input  wire logic            queue_full,
   output logic                 push,
   output pfg_pkg::cmd_type     push_cmd
);
   import pfg_pkg::*;

   logic [31:0] speed_last_ff, speed_last_in;
   logic [31:0] engine_last_ff, engine_last_in;
   logic [31:0] trans_last_ff, trans_last_in;
   logic        speed_due, engine_due, trans_due;
   logic        is_tick;

   assign req_port.ready = !queue_full;
   assign push           = req_port.valid && !queue_full;
   assign is_tick        = (req_port.kind != KIND_INJECT);

   // Wrapping elapsed time against each period.
   always_comb begin
      speed_due  = (req_port.now_ms - speed_last_ff)  >= {16'b0, cfg.period_speed_ms};
      engine_due = (req_port.now_ms - engine_last_ff) >= {16'b0, cfg.period_engine_ms};
      trans_due  = (req_port.now_ms - trans_last_ff)  >= {16'b0, cfg.period_trans_ms};
   end

   // Command word for the back end.
   always_comb begin
      push_cmd.inject     = !is_tick;
      push_cmd.code       = req_port.trouble_code;
      push_cmd.room       = req_port.queue_has_room;
      push_cmd.speed_due  = is_tick && speed_due;
      push_cmd.engine_due = is_tick && engine_due;
      push_cmd.trans_due  = is_tick && trans_due;
   end

   // A due timer restarts from the current time.
   always_comb begin
      speed_last_in  = speed_last_ff;
      engine_last_in = engine_last_ff;
      trans_last_in  = trans_last_ff;
      if (push && is_tick) begin
         if (speed_due) begin
            speed_last_in = req_port.now_ms;
         end
         if (engine_due) begin
            engine_last_in = req_port.now_ms;
         end
         if (trans_due) begin
            trans_last_in = req_port.now_ms;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         speed_last_ff  <= '0;
         engine_last_ff <= '0;
         trans_last_ff  <= '0;
      end else begin
         speed_last_ff  <= speed_last_in;
         engine_last_ff <= engine_last_in;
         trans_last_ff  <= trans_last_in;
      end
   end

endmodule
`default_nettype wire

@@ hdl/pfg_queue.sv @@
// Short command queue between the front end and the back end.
`default_nettype none
module pfg_queue #(
   parameter int DEPTH = 2
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            push,
   input  wire pfg_pkg::cmd_type push_cmd,
   input  wire logic            pop,
   output pfg_pkg::cmd_type     pop_cmd,
   output logic                 full,
   output logic                 empty
);
   import pfg_pkg::*;

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   cmd_type         mem_ff [DEPTH];
   logic [AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]   count_ff, count_in;

   assign full    = (count_ff == CW'(DEPTH));
   assign empty   = (count_ff == '0);
   assign pop_cmd = mem_ff[rd_ptr_ff];

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule
`default_nettype wire

@@ hdl/pfg_back.sv @@
// Back end: engine speed ramp, vehicle speed divider, trouble code state and frame output.
`default_nettype none
module pfg_back (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire pfg_pkg::cfg_type cfg,
   input  wire logic             queue_empty,
   input  wire pfg_pkg::cmd_type pop_cmd,
   output logic                  pop,
   input  wire logic             out_ready,
   output logic                  out_valid,
   output pfg_pkg::frame_type    out_frame
);
   import pfg_pkg::*;

   back_state_type state_ff, state_in;
   cmd_type        cmd_ff, cmd_in;
   logic [15:0]    rpm_ff, rpm_in;
   logic           down_ff, down_in;
   logic           pend_ff, pend_in;
   logic [15:0]    pend_code_ff, pend_code_in;
   logic [15:0]    range_ff, range_in;
   logic           zero_ff, zero_in;
   logic [16:0]    rem_ff, rem_in;
   logic [31:0]    quo_ff, quo_in;
   logic [4:0]     cnt_ff, cnt_in;
   logic [15:0]    speed_ff, speed_in;
   logic [3:0]     mask_ff, mask_in;
   logic [15:0]    code_out_ff, code_out_in;
   logic           out_valid_ff, out_valid_in;
   frame_type      out_frame_ff, out_frame_in;

   logic signed [17:0] step_next;
   logic           ge_ceil, le_floor;
   logic [16:0]    mid_sum;
   logic           arm, code_go;
   logic [16:0]    trial;
   logic           trial_fits;
   logic           out_free, load;
   logic [3:0]     low_bit, mask_rest;
   frame_type      frame_next;

   assign out_free  = !out_valid_ff || out_ready;
   assign out_valid = out_valid_ff;
   assign out_frame = out_frame_ff;

   // Ramp step without wrap, compared against both ends.
   always_comb begin
      if (down_ff) begin
         step_next = $signed({2'b0, rpm_ff}) - $signed({2'b0, cfg.rpm_increment});
      end else begin
         step_next = $signed({2'b0, rpm_ff}) + $signed({2'b0, cfg.rpm_increment});
      end
      ge_ceil  = step_next >= $signed({2'b0, cfg.rpm_ceiling});
      le_floor = step_next <= $signed({2'b0, cfg.rpm_floor});
   end

   // Fault arming and the decision on the trouble code frame.
   always_comb begin
      mid_sum = {1'b0, cfg.rpm_floor} + {1'b0, cfg.rpm_ceiling};
      arm     = cmd_ff.trans_due && (cfg.profile_mode == MODE_FAULT) && !pend_ff
                && (rpm_ff > mid_sum[16:1]);
      code_go = cmd_ff.room && (pend_ff || arm);
   end

   // One restoring division step.
   always_comb begin
      trial      = {rem_ff[15:0], quo_ff[31]};
      trial_fits = trial >= {1'b0, range_ff};
   end

   // Lowest pending frame slot: speed, engine, transmission, code.
   always_comb begin
      low_bit   = mask_ff & (~mask_ff + 4'd1);
      mask_rest = mask_ff & ~low_bit;
   end

   // Frame contents for the selected slot.
   always_comb begin
      frame_next.last = (mask_rest == 4'b0);
      case (low_bit)
         4'b0001: begin
            frame_next.frame_id   = ID_SPEED_FRAME;
            frame_next.byte_count = LEN_SPEED;
            frame_next.payload    = {32'b0, speed_ff[7:0], speed_ff[15:8],
                                     rpm_ff[7:0], rpm_ff[15:8]};
         end
         4'b0010: begin
            frame_next.frame_id   = ID_ENGINE_FRAME;
            frame_next.byte_count = LEN_ENGINE;
            frame_next.payload    = {48'b0, OIL_BYTE, COOLANT_BYTE};
         end
         4'b0100: begin
            frame_next.frame_id   = ID_TRANS_FRAME;
            frame_next.byte_count = LEN_TRANS;
            frame_next.payload    = {56'b0, GEAR_VALUE};
         end
         default: begin
            frame_next.frame_id   = ID_CODE_FRAME;
            frame_next.byte_count = LEN_CODE;
            frame_next.payload    = {48'b0, code_out_ff[7:0], code_out_ff[15:8]};
         end
      endcase
   end

   // Next state of the sequencer.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (!queue_empty && !pop_cmd.inject) begin
               state_in = pop_cmd.speed_due ? ST_RAMP : ST_PLAN;
            end
         end
         ST_RAMP: state_in = ST_MULT;
         ST_MULT: state_in = ST_DIV;
         ST_DIV: begin
            if (cnt_ff == 5'd31) begin
               state_in = ST_PLAN;
            end
         end
         ST_PLAN: state_in = ST_EMIT;
         ST_EMIT: begin
            if (mask_ff == 4'b0) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Sequencer outputs.
   always_comb begin
      pop  = (state_ff == ST_IDLE) && !queue_empty;
      load = (state_ff == ST_EMIT) && (mask_ff != 4'b0) && out_free;
   end

   // Datapath next values.
   always_comb begin
      cmd_in       = cmd_ff;
      rpm_in       = rpm_ff;
      down_in      = down_ff;
      pend_in      = pend_ff;
      pend_code_in = pend_code_ff;
      range_in     = range_ff;
      zero_in      = zero_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      cnt_in       = cnt_ff;
      speed_in     = speed_ff;
      mask_in      = mask_ff;
      code_out_in  = code_out_ff;
      case (state_ff)
         ST_IDLE: begin
            if (pop) begin
               cmd_in = pop_cmd;
               if (pop_cmd.inject) begin
                  pend_code_in = pop_cmd.code;
                  pend_in      = 1'b1;
               end
            end
         end
         ST_RAMP: begin
            if (cfg.profile_mode == MODE_IDLE) begin
               rpm_in = cfg.rpm_floor;
            end else if (ge_ceil) begin
               rpm_in  = cfg.rpm_ceiling;
               down_in = 1'b1;
            end else if (le_floor) begin
               rpm_in  = cfg.rpm_floor;
               down_in = 1'b0;
            end else begin
               rpm_in = step_next[15:0];
            end
         end
         ST_MULT: begin
            zero_in  = (cfg.rpm_ceiling <= cfg.rpm_floor) || (rpm_ff <= cfg.rpm_floor);
            range_in = cfg.rpm_ceiling - cfg.rpm_floor;
            quo_in   = 32'(cfg.speed_top_x10) * 32'(16'(rpm_ff - cfg.rpm_floor));
            rem_in   = '0;
            cnt_in   = '0;
         end
         ST_DIV: begin
            rem_in = trial_fits ? trial - {1'b0, range_ff} : trial;
            quo_in = {quo_ff[30:0], trial_fits};
            cnt_in = cnt_ff + 5'd1;
         end
         ST_PLAN: begin
            if (zero_ff) begin
               speed_in = '0;
            end else if (quo_ff[31:16] != 16'b0) begin
               speed_in = 16'hFFFF;
            end else begin
               speed_in = quo_ff[15:0];
            end
            mask_in     = {code_go, cmd_ff.trans_due, cmd_ff.engine_due, cmd_ff.speed_due};
            code_out_in = arm ? OVERREV_CODE : pend_code_ff;
            if (arm) begin
               pend_code_in = OVERREV_CODE;
               pend_in      = 1'b1;
            end
            if (code_go) begin
               pend_in = 1'b0;
            end
         end
         ST_EMIT: begin
            if (load) begin
               mask_in = mask_rest;
            end
         end
         default: ;
      endcase
   end

   // Output register.
   always_comb begin
      out_valid_in = load || (out_valid_ff && !out_ready);
      out_frame_in = load ? frame_next : out_frame_ff;
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rpm_ff       <= RST_RPM_FLOOR;
         down_ff      <= 1'b0;
         pend_ff      <= 1'b0;
         pend_code_ff <= '0;
         cnt_ff       <= '0;
         mask_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rpm_ff       <= rpm_in;
         down_ff      <= down_in;
         pend_ff      <= pend_in;
         pend_code_ff <= pend_code_in;
         cnt_ff       <= cnt_in;
         mask_ff      <= mask_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      range_ff     <= range_in;
      zero_ff      <= zero_in;
      rem_ff       <= rem_in;
      quo_ff       <= quo_in;
      speed_ff     <= speed_in;
      code_out_ff  <= code_out_in;
      out_frame_ff <= out_frame_in;
   end

   // No frame slots are left over once the sequencer is back in idle.
   a_idle_mask: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> mask_ff == 4'b0)
      else $error("frame slots left pending in idle");

   // A frame marked last leaves no further slots.
   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      load && frame_next.last |=> mask_ff == 4'b0)
      else $error("slots remain after last frame");

   // The divider only runs on a non-empty range, unless the speed is forced to zero.
   a_div_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIV |-> (range_ff != 16'b0) || zero_ff)
      else $error("divider running on empty range");

endmodule
`default_nettype wire

@@ hdl/periodic_can_frame_generator.sv @@
// Top level of the periodic frame generator: registers, front end, queue and back end.
//
//  Channel   Direction  Protocol        Word
//  req_port  in         valid/ready     tick or trouble code inject
//  rsp_port  out        valid/ready     one frame (id, byte count, payload, last)
//  csr_*     in/out     APB-style       eight configuration registers at 4*i
//
// A tick that makes the speed frame due passes the ramp, multiply and 32-step restoring
// divider states for the vehicle speed; other ticks go straight to planning. Frames leave
// at one per cycle while the result channel is free; an inject word only stores its code.
// Reset is synchronous and active high; it clears the timers, the ramp and any pending code.
// The front end keeps accepting words while the command queue has room, so a stalled
// result channel only holds the back end.
`default_nettype none
module periodic_can_frame_generator #(
   parameter int QUEUE_DEPTH = 2
) (
   input  wire logic        clock,
   input  wire logic        reset,
   pfg_req_if.sink          req_port,
   pfg_rsp_if.source        rsp_port,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [4:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);
   import pfg_pkg::*;

   cfg_type   cfg_ff, cfg_in;
   logic [2:0] reg_index;
   logic      csr_write;
   logic      push, pop, queue_full, queue_empty;
   cmd_type   push_cmd, pop_cmd;
   frame_type out_frame;
   logic      out_valid;

   assign csr_pready = 1'b1;
   assign reg_index  = csr_paddr[4:2];
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;

   // Register write decode.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (reg_index)
            REG_PERIOD_SPEED:  cfg_in.period_speed_ms  = csr_pwdata[15:0];
            REG_PERIOD_ENGINE: cfg_in.period_engine_ms = csr_pwdata[15:0];
            REG_PERIOD_TRANS:  cfg_in.period_trans_ms  = csr_pwdata[15:0];
            REG_RPM_FLOOR:     cfg_in.rpm_floor        = csr_pwdata[15:0];
            REG_RPM_CEILING:   cfg_in.rpm_ceiling      = csr_pwdata[15:0];
            REG_RPM_INCREMENT: cfg_in.rpm_increment    = csr_pwdata[15:0];
            REG_SPEED_TOP:     cfg_in.speed_top_x10    = csr_pwdata[15:0];
            REG_PROFILE_MODE:  cfg_in.profile_mode     = csr_pwdata[1:0];
            default: ;
         endcase
      end
   end

   // Register read-back.
   always_comb begin
      case (reg_index)
         REG_PERIOD_SPEED:  csr_prdata = {16'b0, cfg_ff.period_speed_ms};
         REG_PERIOD_ENGINE: csr_prdata = {16'b0, cfg_ff.period_engine_ms};
         REG_PERIOD_TRANS:  csr_prdata = {16'b0, cfg_ff.period_trans_ms};
         REG_RPM_FLOOR:     csr_prdata = {16'b0, cfg_ff.rpm_floor};
         REG_RPM_CEILING:   csr_prdata = {16'b0, cfg_ff.rpm_ceiling};
         REG_RPM_INCREMENT: csr_prdata = {16'b0, cfg_ff.rpm_increment};
         REG_SPEED_TOP:     csr_prdata = {16'b0, cfg_ff.speed_top_x10};
         REG_PROFILE_MODE:  csr_prdata = {30'b0, cfg_ff.profile_mode};
         default:           csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.period_speed_ms  <= RST_PERIOD_SPEED;
         cfg_ff.period_engine_ms <= RST_PERIOD_ENGINE;
         cfg_ff.period_trans_ms  <= RST_PERIOD_TRANS;
         cfg_ff.rpm_floor        <= RST_RPM_FLOOR;
         cfg_ff.rpm_ceiling      <= RST_RPM_CEILING;
         cfg_ff.rpm_increment    <= RST_RPM_INCREMENT;
         cfg_ff.speed_top_x10    <= RST_SPEED_TOP;
         cfg_ff.profile_mode     <= MODE_RAMP;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   pfg_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_port   (req_port),
      .cfg        (cfg_ff),
      .queue_full (queue_full),
      .push       (push),
      .push_cmd   (push_cmd)
   );

   pfg_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .pop_cmd  (pop_cmd),
      .full     (queue_full),
      .empty    (queue_empty)
   );

   pfg_back u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .queue_empty (queue_empty),
      .pop_cmd     (pop_cmd),
      .pop         (pop),
      .out_ready   (rsp_port.ready),
      .out_valid   (out_valid),
      .out_frame   (out_frame)
   );

   // Result channel.
   assign rsp_port.valid      = out_valid;
   assign rsp_port.frame_id   = out_frame.frame_id;
   assign rsp_port.byte_count = out_frame.byte_count;
   assign rsp_port.payload    = out_frame.payload;
   assign rsp_port.last       = out_frame.last;

endmodule
`default_nettype wire
